[hdl/rgbc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_pkg - shared types and constants
// Widths, codes, reset values and the configuration bundle of the gshare
// predictor with perceptron chooser.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    // Default table geometry
    localparam int GSHARE_INDEX_BITS_DEF = 12;
    localparam int ROUTER_INDEX_BITS_DEF = 10;
    localparam int HISTORY_BITS_DEF      = 16;

    // Fixed structure
    localparam int ROUTER_TABLES = 4;
    localparam int SLICE_SHIFT   = 5;

    // Beat field widths
    localparam int ACTION_W = 2;
    localparam int PC_W     = 64;
    localparam int SNAP_W   = 16;

    // Counters and weights
    localparam int CTR_W = 3;
    localparam logic [CTR_W-1:0] CTR_INIT = 3'd4;
    localparam logic [CTR_W-1:0] CTR_MAX  = 3'd7;
    localparam logic [CTR_W-1:0] CTR_MIN  = 3'd0;

    localparam int WEIGHT_W = 8;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_INIT = 8'sd1;
    localparam int SUM_W = WEIGHT_W + 2;

    // Configuration registers
    localparam int THR_W = 10;
    localparam int CMP_W = 11;
    localparam logic signed [THR_W-1:0]    THR_RESET  = 10'sd2;
    localparam logic signed [WEIGHT_W-1:0] WMAX_RESET = 8'sd31;
    localparam logic signed [WEIGHT_W-1:0] WMIN_RESET = -8'sd32;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PREDICT = 2'd0,
        ACT_SHIFT   = 2'd1,
        ACT_TRAIN   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WMAX      = 2'd1,
        REG_WMIN      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [THR_W-1:0]    threshold;
        logic signed [WEIGHT_W-1:0] weight_max;
        logic signed [WEIGHT_W-1:0] weight_min;
    } rgbc_cfg_t;

endpackage
`default_nettype wire

[hdl/rgbc_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_if - request and result channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface rgbc_in_if
    import rgbc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PC_W-1:0]     branch_pc;
    logic                external_pred;
    logic                outcome_taken;
    logic [SNAP_W-1:0]   saved_history;
    logic                saved_gshare_pred;
    logic                saved_external_pred;

    modport source (
        output valid, action, branch_pc, external_pred, outcome_taken,
               saved_history, saved_gshare_pred, saved_external_pred,
        input  ready
    );
    modport sink (
        input  valid, action, branch_pc, external_pred, outcome_taken,
               saved_history, saved_gshare_pred, saved_external_pred,
        output ready
    );
endinterface

interface rgbc_out_if
    import rgbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              final_pred;
    logic              chose_external;
    logic [SNAP_W-1:0] history_snapshot;
    logic              gshare_pred;

    modport source (
        output valid, final_pred, chose_external, history_snapshot, gshare_pred,
        input  ready
    );
    modport sink (
        input  valid, final_pred, chose_external, history_snapshot, gshare_pred,
        output ready
    );
endinterface
`default_nettype wire

[hdl/rgbc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_ram - one-read one-write synchronous RAM
// Registered read data, updated only on a read.
// ----------------------------------------------------------------------------
module rgbc_ram #(
    parameter int ADDR_BITS = 4,
    parameter int DATA_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[hdl/rgbc_apb_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_apb_regs - configuration register file
// APB-style slave holding the chooser threshold and weight bounds.
// ----------------------------------------------------------------------------
module rgbc_apb_regs
    import rgbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output rgbc_cfg_t                  cfg
);

    logic signed [THR_W-1:0]    thr_reg,  thr_next;
    logic signed [WEIGHT_W-1:0] wmax_reg, wmax_next;
    logic signed [WEIGHT_W-1:0] wmin_reg, wmin_next;
    logic [1:0]                 reg_idx;
    logic                       wr_hit;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_hit  = psel & penable & pwrite & pready;

    always_comb
    begin
        thr_next  = thr_reg;
        wmax_next = wmax_reg;
        wmin_next = wmin_reg;
        if (wr_hit)
        begin
            case (reg_idx)
                REG_THRESHOLD: thr_next  = $signed(pwdata[THR_W-1:0]);
                REG_WMAX:      wmax_next = $signed(pwdata[WEIGHT_W-1:0]);
                REG_WMIN:      wmin_next = $signed(pwdata[WEIGHT_W-1:0]);
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            wmax_reg <= WMAX_RESET;
            wmin_reg <= WMIN_RESET;
        end
        else
        begin
            thr_reg  <= thr_next;
            wmax_reg <= wmax_next;
            wmin_reg <= wmin_next;
        end
    end

    // Return sign-extended register contents
    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(thr_reg);
            REG_WMAX:      prdata = APB_DATA_W'(wmax_reg);
            REG_WMIN:      prdata = APB_DATA_W'(wmin_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.threshold  = thr_reg;
    assign cfg.weight_max = wmax_reg;
    assign cfg.weight_min = wmin_reg;

endmodule
`default_nettype wire

[hdl/rgbc_router.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgbc_router - perceptron chooser tables
// Four weight banks: hashed read, signed sum against threshold, saturating
// read-modify-write of the row, and clear-pass writes.
// ----------------------------------------------------------------------------
module rgbc_router
    import rgbc_pkg::*;
#(
    parameter int ROUTER_INDEX_BITS = ROUTER_INDEX_BITS_DEF,
    parameter int HISTORY_BITS      = HISTORY_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [PC_W-1:0]              pc,
    input  wire logic [HISTORY_BITS-1:0]      hist,
    input  wire logic                         wr_en,
    input  wire logic                         step_up,
    input  wire logic                         clr_en,
    input  wire logic [ROUTER_INDEX_BITS-1:0] clr_addr,
    input  wire rgbc_cfg_t                    cfg,
    output logic                              use_ext
);

    logic [PC_W-1:0]              p;
    logic [PC_W-1:0]              h;
    logic [PC_W-1:0]              mix      [ROUTER_TABLES];
    logic [ROUTER_INDEX_BITS-1:0] rd_idx   [ROUTER_TABLES];
    logic [ROUTER_INDEX_BITS-1:0] idx_reg  [ROUTER_TABLES];
    logic [WEIGHT_W-1:0]          rd_word  [ROUTER_TABLES];
    logic signed [WEIGHT_W-1:0]   w_cur    [ROUTER_TABLES];
    logic signed [WEIGHT_W-1:0]   w_step   [ROUTER_TABLES];
    logic [ROUTER_INDEX_BITS-1:0] wr_addr  [ROUTER_TABLES];
    logic [WEIGHT_W-1:0]          wr_word  [ROUTER_TABLES];
    logic signed [SUM_W-1:0]      sum;

    assign p = pc >> 2;
    assign h = PC_W'(hist);

    assign mix[0] = p;
    assign mix[1] = p ^ h;
    assign mix[2] = p ^ (h >> SLICE_SHIFT);
    assign mix[3] = p ^ h ^ (h >> ROUTER_INDEX_BITS);

    genvar t;
    generate
        for (t = 0; t < ROUTER_TABLES; t++)
        begin : g_bank
            assign rd_idx[t] = mix[t][ROUTER_INDEX_BITS-1:0];

            // Hold the row address for the write-back
            always_ff @(posedge clk)
            begin
                if (rd_en)
                begin
                    idx_reg[t] <= rd_idx[t];
                end
            end

            assign w_cur[t] = $signed(rd_word[t]);

            always_comb
            begin
                w_step[t] = w_cur[t];
                if (step_up)
                begin
                    if (w_cur[t] < cfg.weight_max)
                    begin
                        w_step[t] = w_cur[t] + 8'sd1;
                    end
                end
                else
                begin
                    if (w_cur[t] > cfg.weight_min)
                    begin
                        w_step[t] = w_cur[t] - 8'sd1;
                    end
                end
            end

            assign wr_addr[t] = clr_en ? clr_addr : idx_reg[t];
            assign wr_word[t] = clr_en ? WEIGHT_INIT : w_step[t];

            rgbc_ram #(
                .ADDR_BITS (ROUTER_INDEX_BITS),
                .DATA_BITS (WEIGHT_W)
            ) u_bank (
                .clk     (clk),
                .rd_en   (rd_en),
                .rd_addr (rd_idx[t]),
                .rd_data (rd_word[t]),
                .wr_en   (clr_en | wr_en),
                .wr_addr (wr_addr[t]),
                .wr_data (wr_word[t])
            );
        end
    endgenerate

    assign sum = SUM_W'(w_cur[0]) + SUM_W'(w_cur[1])
               + SUM_W'(w_cur[2]) + SUM_W'(w_cur[3]);

    assign use_ext = CMP_W'(sum) > CMP_W'(cfg.threshold);

endmodule
`default_nettype wire

[hdl/routed_gshare_branch_chooser_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// routed_gshare_branch_chooser_unit - gshare predictor with perceptron chooser
// Predict, history-shift and train beats over one gshare table and four
// router weight tables held in synchronous RAM.
// ----------------------------------------------------------------------------
// Flow: a taken beat waits in the stage until the result register is free.
//   The tables are read at accept and written back as the stage retires, and
//   one beat is in the stage at a time: no new beat is taken until it retires.
// Reset: history clears and config registers load their reset values at once;
//   a clear pass then writes 2**max(GSHARE_INDEX_BITS, ROUTER_INDEX_BITS) rows
//   (4096 rows by default) while requests are held off. Config writes are
//   taken throughout.
// ----------------------------------------------------------------------------
module routed_gshare_branch_chooser_unit
    import rgbc_pkg::*;
#(
    parameter int GSHARE_INDEX_BITS = GSHARE_INDEX_BITS_DEF,
    parameter int ROUTER_INDEX_BITS = ROUTER_INDEX_BITS_DEF,
    parameter int HISTORY_BITS      = HISTORY_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rgbc_in_if.sink                    in_ch,
    rgbc_out_if.source                 out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CLR_BITS = (GSHARE_INDEX_BITS > ROUTER_INDEX_BITS)
                            ? GSHARE_INDEX_BITS : ROUTER_INDEX_BITS;

    rgbc_cfg_t cfg;

    // Clear pass
    logic                clearing_reg, clearing_next;
    logic [CLR_BITS-1:0] clr_cnt_reg,  clr_cnt_next;

    // Global history
    logic [HISTORY_BITS-1:0] hist_reg, hist_next;
    logic [HISTORY_BITS-1:0] saved_hist;
    logic [HISTORY_BITS-1:0] hist_sel;

    // In-flight stage
    logic                         s1_valid_reg, s1_valid_next;
    logic [ACTION_W-1:0]          act_reg;
    logic                         ext_reg;
    logic                         taken_reg;
    logic                         disagree_reg;
    logic                         ext_right_reg;
    logic [SNAP_W-1:0]            snap_reg;
    logic [GSHARE_INDEX_BITS-1:0] gs_idx_reg;

    // Result register
    logic              out_valid_reg,   out_valid_next;
    logic              final_pred_reg,  final_pred_next;
    logic              chose_ext_reg,   chose_ext_next;
    logic [SNAP_W-1:0] snap_out_reg,    snap_out_next;
    logic              gshare_pred_reg, gshare_pred_next;

    logic                         accept;
    logic                         s1_done;
    logic                         s1_train;
    logic [PC_W-1:0]              gs_mix;
    logic [GSHARE_INDEX_BITS-1:0] gs_rd_idx;
    logic [CTR_W-1:0]             gs_ctr;
    logic [CTR_W-1:0]             gs_ctr_step;
    logic                         gs_wr_en;
    logic [GSHARE_INDEX_BITS-1:0] gs_wr_addr;
    logic [CTR_W-1:0]             gs_wr_data;
    logic                         gshare_pred;
    logic                         use_ext;

    // ------------------------------------------------------------------------
    // Handshake: take a beat only with the stage empty and the tables cleared.
    // The result register frees the stage, so a new beat may enter while an
    // earlier result still waits on the output.
    // ------------------------------------------------------------------------
    assign in_ch.ready = ~clearing_reg & ~s1_valid_reg;
    assign accept      = in_ch.valid & in_ch.ready;
    assign s1_done     = s1_valid_reg & (~out_valid_reg | out_ch.ready);
    assign s1_train    = (act_reg == ACT_TRAIN);

    // Train beats index with the returned snapshot; others use live history.
    assign saved_hist = HISTORY_BITS'(in_ch.saved_history);
    assign hist_sel   = (in_ch.action == ACT_TRAIN) ? saved_hist : hist_reg;

    // Shift in the outcome on a history beat
    assign hist_next = (accept && in_ch.action == ACT_SHIFT)
                     ? HISTORY_BITS'({hist_reg, in_ch.outcome_taken})
                     : hist_reg;

    assign gs_mix    = (in_ch.branch_pc >> 2) ^ PC_W'(hist_sel);
    assign gs_rd_idx = gs_mix[GSHARE_INDEX_BITS-1:0];

    // ------------------------------------------------------------------------
    // Clear pass: sweep every row once after reset, restoring counters to
    // weakly taken and weights to one. The narrower table wraps and rewrites
    // the same reset value, which is harmless.
    // ------------------------------------------------------------------------
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {CLR_BITS{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // gshare table: read at accept, saturating step on a train beat when the
    // stage retires.
    // ------------------------------------------------------------------------
    assign gshare_pred = (gs_ctr >= CTR_INIT);

    always_comb
    begin
        gs_ctr_step = gs_ctr;
        if (taken_reg)
        begin
            if (gs_ctr < CTR_MAX)
            begin
                gs_ctr_step = gs_ctr + 1'b1;
            end
        end
        else
        begin
            if (gs_ctr > CTR_MIN)
            begin
                gs_ctr_step = gs_ctr - 1'b1;
            end
        end
    end

    assign gs_wr_en   = clearing_reg | (s1_done & s1_train);
    assign gs_wr_addr = clearing_reg ? clr_cnt_reg[GSHARE_INDEX_BITS-1:0] : gs_idx_reg;
    assign gs_wr_data = clearing_reg ? CTR_INIT : gs_ctr_step;

    rgbc_ram #(
        .ADDR_BITS (GSHARE_INDEX_BITS),
        .DATA_BITS (CTR_W)
    ) u_gshare (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (gs_rd_idx),
        .rd_data (gs_ctr),
        .wr_en   (gs_wr_en),
        .wr_addr (gs_wr_addr),
        .wr_data (gs_wr_data)
    );

    // ------------------------------------------------------------------------
    // Router: weights step only when the two sources disagreed, toward the
    // external side when it matched the outcome.
    // ------------------------------------------------------------------------
    rgbc_router #(
        .ROUTER_INDEX_BITS (ROUTER_INDEX_BITS),
        .HISTORY_BITS      (HISTORY_BITS)
    ) u_router (
        .clk      (clk),
        .rd_en    (accept),
        .pc       (in_ch.branch_pc),
        .hist     (hist_sel),
        .wr_en    (s1_done & s1_train & disagree_reg),
        .step_up  (ext_right_reg),
        .clr_en   (clearing_reg),
        .clr_addr (clr_cnt_reg[ROUTER_INDEX_BITS-1:0]),
        .cfg      (cfg),
        .use_ext  (use_ext)
    );

    rgbc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------------
    // Stage and result control. Non-predict beats return all-zero fields.
    // ------------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        out_valid_next   = out_valid_reg;
        final_pred_next  = final_pred_reg;
        chose_ext_next   = chose_ext_reg;
        snap_out_next    = snap_out_reg;
        gshare_pred_next = gshare_pred_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_done)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            if (act_reg == ACT_PREDICT)
            begin
                final_pred_next  = use_ext ? ext_reg : gshare_pred;
                chose_ext_next   = use_ext;
                snap_out_next    = snap_reg;
                gshare_pred_next = gshare_pred;
            end
            else
            begin
                final_pred_next  = 1'b0;
                chose_ext_next   = 1'b0;
                snap_out_next    = '0;
                gshare_pred_next = 1'b0;
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            hist_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            hist_reg      <= hist_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold until the stage retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg       <= in_ch.action;
            ext_reg       <= in_ch.external_pred;
            taken_reg     <= in_ch.outcome_taken;
            disagree_reg  <= in_ch.saved_external_pred ^ in_ch.saved_gshare_pred;
            ext_right_reg <= (in_ch.saved_external_pred == in_ch.outcome_taken);
            snap_reg      <= SNAP_W'(hist_reg);
            gs_idx_reg    <= gs_rd_idx;
        end
        final_pred_reg  <= final_pred_next;
        chose_ext_reg   <= chose_ext_next;
        snap_out_reg    <= snap_out_next;
        gshare_pred_reg <= gshare_pred_next;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.final_pred       = final_pred_reg;
    assign out_ch.chose_external   = chose_ext_reg;
    assign out_ch.history_snapshot = snap_out_reg;
    assign out_ch.gshare_pred      = gshare_pred_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat did not enter the stage");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_done) |=> s1_valid_reg)
        else $error("stalled beat dropped from the stage");

    a_no_work_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !out_valid_reg))
        else $error("table access during clear pass");

    a_retire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_done |=> out_valid_reg)
        else $error("retired beat produced no result");

    a_clear_ends_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == {CLR_BITS{1'b1}}))
        else $error("clear pass ended early");

endmodule
`default_nettype wire

[bench/tb_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_checker - result predictor and scoreboard for the branch chooser
// Watches the request, result and register channels. Keeps its own gshare
// counters, router weights, history and register copies, predicts one
// result per accepted request and compares each result beat in order.
// ----------------------------------------------------------------------------
module tb_checker
    import rgbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rgbc_in_if                         in_mon,
    rgbc_out_if                        out_mon,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic                  pready,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output int                         errors,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GS_BITS   = GSHARE_INDEX_BITS_DEF;
    localparam int RT_BITS   = ROUTER_INDEX_BITS_DEF;
    localparam int HIST_BITS = HISTORY_BITS_DEF;
    localparam int GS_SIZE   = 1 << GS_BITS;
    localparam int RT_SIZE   = 1 << RT_BITS;

    typedef struct packed {
        logic              final_pred;
        logic              chose_external;
        logic [SNAP_W-1:0] history_snapshot;
        logic              gshare_pred;
    } choice_t;

    logic        [CTR_W-1:0]    gs_ctr    [GS_SIZE];
    logic signed [WEIGHT_W-1:0] route_wt  [ROUTER_TABLES][RT_SIZE];
    logic        [HIST_BITS-1:0] ghist;
    logic signed [THR_W-1:0]    thr;
    logic signed [WEIGHT_W-1:0] wt_max;
    logic signed [WEIGHT_W-1:0] wt_min;

    choice_t due_choices[$];
    int      result_no;

    function automatic logic [GS_BITS-1:0] gs_slot(logic [PC_W-1:0] pc,
                                                   logic [HIST_BITS-1:0] h);
        logic [PC_W-1:0] p;
        p = pc >> 2;
        return p[GS_BITS-1:0] ^ GS_BITS'(h);
    endfunction

    function automatic logic [RT_BITS-1:0] route_slot(int t, logic [PC_W-1:0] pc,
                                                      logic [HIST_BITS-1:0] h);
        logic [PC_W-1:0]      p;
        logic [HIST_BITS-1:0] mix;
        p = pc >> 2;
        case (t)
            0:       mix = '0;
            1:       mix = h;
            2:       mix = h >> SLICE_SHIFT;
            default: mix = h ^ (h >> RT_BITS);
        endcase
        return p[RT_BITS-1:0] ^ RT_BITS'(mix);
    endfunction

    // Apply one request beat to the shadow tables and return its result.
    function automatic choice_t apply_request();
        choice_t                    res;
        logic [PC_W-1:0]            pc;
        logic [HIST_BITS-1:0]       sh;
        logic [CTR_W-1:0]           c;
        logic signed [WEIGHT_W-1:0] w;
        logic [RT_BITS-1:0]         slot;
        logic                       fp;
        logic                       pick_ext;
        int                         sum;
        res = '0;
        pc  = in_mon.branch_pc;
        sh  = HIST_BITS'(in_mon.saved_history);
        case (in_mon.action)
            ACT_PREDICT:
            begin
                fp  = gs_ctr[gs_slot(pc, ghist)] >= CTR_INIT;
                sum = 0;
                for (int t = 0; t < ROUTER_TABLES; t++)
                begin
                    sum += route_wt[t][route_slot(t, pc, ghist)];
                end
                pick_ext             = sum > int'(thr);
                res.final_pred       = pick_ext ? in_mon.external_pred : fp;
                res.chose_external   = pick_ext;
                res.history_snapshot = SNAP_W'(ghist);
                res.gshare_pred      = fp;
            end
            ACT_SHIFT:
            begin
                ghist = {ghist[HIST_BITS-2:0], in_mon.outcome_taken};
            end
            ACT_TRAIN:
            begin
                c = gs_ctr[gs_slot(pc, sh)];
                if (in_mon.outcome_taken)
                begin
                    if (c < CTR_MAX) c = c + 1'b1;
                end
                else
                begin
                    if (c > CTR_MIN) c = c - 1'b1;
                end
                gs_ctr[gs_slot(pc, sh)] = c;
                // Router learns only when the two sources disagreed.
                if (in_mon.saved_external_pred != in_mon.saved_gshare_pred)
                begin
                    for (int t = 0; t < ROUTER_TABLES; t++)
                    begin
                        slot = route_slot(t, pc, sh);
                        w    = route_wt[t][slot];
                        if (in_mon.saved_external_pred == in_mon.outcome_taken)
                        begin
                            if (w < wt_max) w = w + 8'sd1;
                        end
                        else
                        begin
                            if (w > wt_min) w = w - 8'sd1;
                        end
                        route_wt[t][slot] = w;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report(string msg);
        $display("tb_checker: result %0d: %s", result_no, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        choice_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < GS_SIZE; i++) gs_ctr[i] = CTR_INIT;
            for (int t = 0; t < ROUTER_TABLES; t++)
            begin
                for (int i = 0; i < RT_SIZE; i++) route_wt[t][i] = WEIGHT_INIT;
            end
            ghist  = '0;
            thr    = THR_RESET;
            wt_max = WMAX_RESET;
            wt_min = WMIN_RESET;
            due_choices.delete();
            result_no   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_THRESHOLD: thr    = pwdata[THR_W-1:0];
                    REG_WMAX:      wt_max = pwdata[WEIGHT_W-1:0];
                    REG_WMIN:      wt_min = pwdata[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (due_choices.size() == 0)
                begin
                    report("result beat with nothing outstanding");
                end
                else
                begin
                    want = due_choices.pop_front();
                    if (out_mon.final_pred !== want.final_pred)
                        report($sformatf("final_pred %b, want %b",
                                         out_mon.final_pred, want.final_pred));
                    if (out_mon.chose_external !== want.chose_external)
                        report($sformatf("chose_external %b, want %b",
                                         out_mon.chose_external, want.chose_external));
                    if (out_mon.history_snapshot !== want.history_snapshot)
                        report($sformatf("history_snapshot %h, want %h",
                                         out_mon.history_snapshot, want.history_snapshot));
                    if (out_mon.gshare_pred !== want.gshare_pred)
                        report($sformatf("gshare_pred %b, want %b",
                                         out_mon.gshare_pred, want.gshare_pred));
                end
                result_no++;
            end
            if (in_mon.valid && in_mon.ready)
            begin
                due_choices.push_back(apply_request());
            end
            outstanding <= due_choices.size();
        end
    end

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top - stimulus and verdict for the routed gshare branch chooser
// Drives predict, history-shift and train beats with random gaps and result
// stalls, rewrites the chooser registers between phases, and leaves all
// prediction and comparison to the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_top
    import rgbc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Action code the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int PHASES       = 6;
    localparam int BEATS_PER_PH = 188;
    localparam int PC_POOL      = 8;
    localparam int SETTLE       = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PC_W-1:0]     pc;
        logic                ext;
        logic                taken;
        logic [SNAP_W-1:0]   saved_h;
        logic                saved_fast;
        logic                saved_ext;
    } branch_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int outstanding;

    // Idling switch for both sides; cleared for the last phase.
    logic idle_on;
    int   stall_left;

    // Shadow of the global history, built from the shift beats we send, so
    // that train beats can carry the snapshot a real fetch unit would hold.
    logic [SNAP_W-1:0] hist_track;
    logic [PC_W-1:0]   pc_pool   [PC_POOL];
    logic              pc_lean   [PC_POOL];

    rgbc_in_if  in_ch ();
    rgbc_out_if out_ch ();

    routed_gshare_branch_chooser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Result side: hold ready low in random bursts while idling
    // is on, otherwise take every result beat at once.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            stall_left   <= $urandom_range(0, 8);
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // Every field random; callers then pin the fields that matter.
    function automatic branch_req_t random_req();
        branch_req_t r;
        r.action     = ACTION_W'($urandom_range(0, 3));
        r.pc         = {$urandom, $urandom};
        r.ext        = 1'($urandom_range(0, 1));
        r.taken      = 1'($urandom_range(0, 1));
        r.saved_h    = SNAP_W'($urandom);
        r.saved_fast = 1'($urandom_range(0, 1));
        r.saved_ext  = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic branch_req_t mk_predict(logic [PC_W-1:0] pc, logic ext);
        branch_req_t r;
        r        = random_req();
        r.action = ACT_PREDICT;
        r.pc     = pc;
        r.ext    = ext;
        return r;
    endfunction

    function automatic branch_req_t mk_shift(logic taken);
        branch_req_t r;
        r        = random_req();
        r.action = ACT_SHIFT;
        r.taken  = taken;
        return r;
    endfunction

    function automatic branch_req_t mk_train(logic [PC_W-1:0] pc, logic [SNAP_W-1:0] sh,
                                             logic fast, logic ext, logic taken);
        branch_req_t r;
        r            = random_req();
        r.action     = ACT_TRAIN;
        r.pc         = pc;
        r.saved_h    = sh;
        r.saved_fast = fast;
        r.saved_ext  = ext;
        r.taken      = taken;
        return r;
    endfunction

    // Send one request beat. Called at a rising edge; returns at the edge
    // that accepted the beat, with valid still high for a back-to-back beat.
    task automatic push_req(branch_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.action              <= r.action;
        in_ch.branch_pc           <= r.pc;
        in_ch.external_pred       <= r.ext;
        in_ch.outcome_taken       <= r.taken;
        in_ch.saved_history       <= r.saved_h;
        in_ch.saved_gshare_pred   <= r.saved_fast;
        in_ch.saved_external_pred <= r.saved_ext;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (r.action == ACT_SHIFT) hist_track = {hist_track[SNAP_W-2:0], r.taken};
    endtask

    // Wait until every predicted result has been taken. The first edge lets
    // the checker's count catch up with the last accepted beat.
    task automatic drain();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Register write: setup, then access until pready.
    task automatic reg_write(reg_idx_t idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Directed opening under the reset register values: address extremes,
    // every action, agreeing and disagreeing trains in both directions,
    // counter saturation and the ignored action code.
    task automatic directed_beats();
        branch_req_t r;
        push_req(mk_predict('0, 1'b0));
        push_req(mk_predict('1, 1'b1));
        push_req(mk_shift(1'b1));
        push_req(mk_shift(1'b0));
        push_req(mk_predict('0, 1'b1));
        // Sources agree: gshare counter only.
        push_req(mk_train('0, '0, 1'b0, 1'b0, 1'b1));
        // External right, then external wrong: router steps both ways.
        push_req(mk_train('0, '0, 1'b1, 1'b0, 1'b0));
        push_req(mk_train('0, '0, 1'b0, 1'b1, 1'b0));
        push_req(mk_train('1, '1, 1'b1, 1'b1, 1'b1));
        push_req(mk_train('1, '1, 1'b0, 1'b1, 1'b1));
        // Ignored action with every field high, then every field low.
        r = '1;
        push_req(r);
        r        = '0;
        r.action = ACT_UNUSED;
        push_req(r);
        // Drive the counter at pc 0 up past its top.
        repeat (5) push_req(mk_train('0, '0, 1'b0, 1'b1, 1'b1));
        push_req(mk_predict('0, 1'b0));
        // And back down toward zero.
        repeat (6) push_req(mk_train('0, '0, 1'b1, 1'b0, 1'b0));
        push_req(mk_predict('1, 1'b0));
    endtask

    // Mostly complete predict / resolve / train sequences over a small pool
    // of branches so that counters and weights move and saturate; the rest
    // is raw noise, the ignored action included.
    task automatic random_beats(int count);
        int                sent;
        int                k;
        logic              taken;
        logic              ext;
        logic [SNAP_W-1:0] snap;
        branch_req_t       r;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                r = random_req();
                push_req(r);
                if (r.action != ACT_UNUSED) sent++;
            end
            else
            begin
                k     = $urandom_range(0, PC_POOL - 1);
                taken = ($urandom_range(0, 4) != 0) ? pc_lean[k] : !pc_lean[k];
                ext   = ($urandom_range(0, 3) != 0) ? taken : !taken;
                snap  = hist_track;
                push_req(mk_predict(pc_pool[k], ext));
                push_req(mk_shift(taken));
                push_req(mk_train(pc_pool[k], snap, 1'($urandom_range(0, 1)), ext, taken));
                sent += 3;
            end
        end
    endtask

    initial
    begin
        int thr_v;
        int max_v;
        int min_v;

        // Known values on the request and register inputs before the first edge.
        rst_n                     = 1'b0;
        idle_on                   = 1'b1;
        hist_track                = '0;
        in_ch.valid               = 1'b0;
        in_ch.action              = ACT_PREDICT;
        in_ch.branch_pc           = '0;
        in_ch.external_pred       = 1'b0;
        in_ch.outcome_taken       = 1'b0;
        in_ch.saved_history       = '0;
        in_ch.saved_gshare_pred   = 1'b0;
        in_ch.saved_external_pred = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        for (int i = 0; i < PC_POOL; i++)
        begin
            pc_pool[i] = {$urandom, $urandom};
            pc_lean[i] = 1'($urandom_range(0, 1));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The clear pass after reset holds ready low; push_req waits it out.
        directed_beats();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            in_ch.valid <= 1'b0;
            drain();
            case (ph)
                0:       begin thr_v = -512; max_v =  127; min_v = -128; end
                1:       begin thr_v =  511; max_v = -128; min_v =  127; end
                2:       begin thr_v =    0; max_v =    3; min_v =   -2; end
                3:       begin thr_v =   -4; max_v =    1; min_v =    1; end
                4:
                begin
                    thr_v = $urandom_range(0, 40) - 20;
                    max_v = $urandom_range(0, 50) - 10;
                    min_v = $urandom_range(0, 50) - 40;
                end
                default: begin thr_v =    2; max_v =   31; min_v =  -32; end
            endcase
            reg_write(REG_THRESHOLD, thr_v);
            reg_write(REG_WMAX, max_v);
            reg_write(REG_WMIN, min_v);
            // Run the last phase flat out on both sides.
            idle_on <= (ph != PHASES - 1);
            random_beats(BEATS_PER_PH);
        end

        in_ch.valid <= 1'b0;
        drain();
        repeat (SETTLE) @(posedge clk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
